### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the core controller (met_ctrl).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### rtl/core/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Widths, constants and controller/datapath interface types for the
// escape-time iterator.
// ----------------------------------------------------------------------------
`default_nettype none

package met_pkg;

    localparam int FRAC_BITS = 28;
    localparam int C_W       = 32;
    localparam int CNT_W     = 12;
    localparam int MAG_W     = 40;

    // |z| before the escape test is below 25*2^F + 2^31
    localparam int Z_BASE = (FRAC_BITS + 5 > C_W - 1) ? FRAC_BITS + 5 : C_W - 1;
    localparam int Z_W    = Z_BASE + 2;                 // signed z components
    localparam int M_W    = Z_W - 1;                    // magnitudes
    localparam int PR_W   = 2 * M_W;                    // full products
    localparam int SQ_W   = PR_W - FRAC_BITS;           // squares after shift
    localparam int CR_W   = PR_W - FRAC_BITS + 1;       // 2*zr*zi after shift
    localparam int SUM_W  = SQ_W + 1;

    localparam logic [SUM_W-1:0] ESC_LIMIT   = SUM_W'(25) << FRAC_BITS;
    localparam logic [SUM_W-1:0] MAG_SAT     = SUM_W'({MAG_W{1'b1}});
    localparam logic [MAG_W-1:0] MAG_MAX     = {MAG_W{1'b1}};
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(256);

    typedef struct packed {
        logic start;     // load c, z = c, count = 1, clear result
        logic mul;       // register squares and cross product
        logic step;      // form next z, advance count
        logic capture;   // latch escape result
        logic load_out;  // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic escape;      // |z|^2 above limit
        logic last;        // current iteration is the final one allowed
        logic limit_zero;  // configured limit is zero
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Fixed-point escape-time iterator for one complex point per request.
// ----------------------------------------------------------------------------
// Each request carries c in signed fixed point with 28 fraction bits. The
// block iterates z = z*z + c from z = 0 and stops at the first iteration k
// where |z|^2 exceeds 25, or after iteration_limit iterations. Each iteration
// passes through a multiply state (the three magnitude multipliers: zr^2,
// zi^2, zr*zi) and then an add state (the add, escape compare and z update).
// The next request is taken once the previous result has moved to the output
// register, so a stalled result does not hold up the next point's work.
// iteration_limit resets to 256; the user must write it only while no
// request is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [met_pkg::CNT_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [met_pkg::C_W-1:0] i_c_real,
    input  wire logic signed [met_pkg::C_W-1:0] i_c_imag,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_escaped,
    output logic [met_pkg::CNT_W-1:0]           o_escape_count,
    output logic [met_pkg::MAG_W-1:0]           o_escape_mag_sq
);

    met_pkg::t_dp_cmd cmd;
    met_pkg::t_dp_sts sts;

    met_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    met_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_c_real        (i_c_real),
        .i_c_imag        (i_c_imag),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_escaped       (o_escaped),
        .o_escape_count  (o_escape_count),
        .o_escape_mag_sq (o_escape_mag_sq)
    );

endmodule

`default_nettype wire

### rtl/core/met_dp.sv
// ----------------------------------------------------------------------------
// met_dp
// Datapath: z registers, three magnitude multipliers, escape test, result
// and output registers, iteration limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module met_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [met_pkg::CNT_W-1:0]     i_cfg_data,
    input  wire logic signed [met_pkg::C_W-1:0] i_c_real,
    input  wire logic signed [met_pkg::C_W-1:0] i_c_imag,
    input  wire met_pkg::t_dp_cmd              i_cmd,
    output met_pkg::t_dp_sts                   o_sts,
    output logic                               o_escaped,
    output logic [met_pkg::CNT_W-1:0]          o_escape_count,
    output logic [met_pkg::MAG_W-1:0]          o_escape_mag_sq
);

    localparam int Z_W   = met_pkg::Z_W;
    localparam int M_W   = met_pkg::M_W;
    localparam int PR_W  = met_pkg::PR_W;
    localparam int SQ_W  = met_pkg::SQ_W;
    localparam int CR_W  = met_pkg::CR_W;
    localparam int SUM_W = met_pkg::SUM_W;
    localparam int F     = met_pkg::FRAC_BITS;

    logic [met_pkg::CNT_W-1:0]     r_limit;
    logic signed [met_pkg::C_W-1:0] r_cr, r_ci;
    logic signed [Z_W-1:0]         r_zr, r_zi;
    logic [met_pkg::CNT_W-1:0]     r_count;
    logic [SQ_W-1:0]               r_zrsq, r_zisq;
    logic [CR_W-1:0]               r_cross;
    logic                          r_cross_neg;
    logic                          r_res_esc;
    logic [met_pkg::CNT_W-1:0]     r_res_cnt;
    logic [met_pkg::MAG_W-1:0]     r_res_mag;
    logic                          r_out_esc;
    logic [met_pkg::CNT_W-1:0]     r_out_cnt;
    logic [met_pkg::MAG_W-1:0]     r_out_mag;

    logic signed [Z_W-1:0] zr_abs_s, zi_abs_s;
    logic [M_W-1:0]        mag_zr, mag_zi;
    logic [PR_W-1:0]       prod_rr, prod_ii, prod_ri;
    logic [SUM_W-1:0]      sum;
    logic signed [Z_W-1:0] cross_s, n_zi, n_zr;

    // magnitudes of z; |z| stays below 2^M_W
    always_comb begin
        zr_abs_s = r_zr[Z_W-1] ? -r_zr : r_zr;
        zi_abs_s = r_zi[Z_W-1] ? -r_zi : r_zi;
        mag_zr   = zr_abs_s[M_W-1:0];
        mag_zi   = zi_abs_s[M_W-1:0];
        prod_rr  = PR_W'(mag_zr) * PR_W'(mag_zr);
        prod_ii  = PR_W'(mag_zi) * PR_W'(mag_zi);
        prod_ri  = PR_W'(mag_zr) * PR_W'(mag_zi);
    end

    // escape test and next z; next z is only used while |z|^2 <= 25,
    // where the squares and the cross term fit in Z_W bits
    always_comb begin
        sum     = SUM_W'(r_zrsq) + SUM_W'(r_zisq);
        cross_s = signed'(r_cross[Z_W-1:0]);
        n_zi    = (r_cross_neg ? -cross_s : cross_s) + Z_W'(r_ci);
        n_zr    = signed'(r_zrsq[Z_W-1:0]) - signed'(r_zisq[Z_W-1:0]) + Z_W'(r_cr);
    end

    assign o_sts.escape     = sum > met_pkg::ESC_LIMIT;
    assign o_sts.last       = r_count == r_limit;
    assign o_sts.limit_zero = r_limit == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= met_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cr      <= i_c_real;
            r_ci      <= i_c_imag;
            // first iteration from z = 0 gives z = c
            r_zr      <= Z_W'(i_c_real);
            r_zi      <= Z_W'(i_c_imag);
            r_count   <= met_pkg::CNT_W'(1);
            r_res_esc <= 1'b0;
            r_res_cnt <= '0;
            r_res_mag <= '0;
        end
        if (i_cmd.mul) begin
            r_zrsq      <= prod_rr[PR_W-1:F];
            r_zisq      <= prod_ii[PR_W-1:F];
            r_cross     <= prod_ri[PR_W-1:F-1];
            r_cross_neg <= r_zr[Z_W-1] ^ r_zi[Z_W-1];
        end
        if (i_cmd.step) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.capture) begin
            r_res_esc <= 1'b1;
            r_res_cnt <= r_count;
            r_res_mag <= (sum > met_pkg::MAG_SAT) ? met_pkg::MAG_MAX
                                                  : sum[met_pkg::MAG_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_esc <= r_res_esc;
            r_out_cnt <= r_res_cnt;
            r_out_mag <= r_res_mag;
        end
    end

    assign o_escaped       = r_out_esc;
    assign o_escape_count  = r_out_cnt;
    assign o_escape_mag_sq = r_out_mag;

endmodule

`default_nettype wire

### rtl/core/met_ctrl.sv
// ----------------------------------------------------------------------------
// met_ctrl
// Controller: request handshakes and iteration sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module met_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire met_pkg::t_dp_sts i_sts,
    output met_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.limit_zero ? S_FIN : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                if (i_sts.escape) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FIN;
                end else if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_cmd_excl, i_clk, i_rst_n, $onehot0(o_cmd), "datapath commands overlap")
    `ASSERT_CLK(a_step_loop, i_clk, i_rst_n, o_cmd.step |=> r_state == S_MUL, "step did not return to multiply")
    `ASSERT_CLK(a_capture_fin, i_clk, i_rst_n, o_cmd.capture |=> r_state == S_FIN, "escape did not finish the request")
    `ASSERT_CLK(a_load_valid, i_clk, i_rst_n, o_cmd.load_out |=> r_out_valid, "loaded result not presented")
    `ASSERT_NEVER(a_load_overwrite, i_clk, i_rst_n, o_cmd.load_out && r_out_valid && i_out_stall, "result overwritten while stalled")

endmodule

`default_nettype wire
